/* rtl/bb_pkg.sv */
// ============================================================================
// bb_pkg: shared types and constants for the 3x3 box blur
// Beat layouts, register indexes, lane control and the reciprocal table.
// ============================================================================
`default_nettype none
package bb_pkg;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int HEIGHT_LIMIT  = 4096;
  localparam int FW_W          = 11;
  localparam int FH_W          = 13;
  localparam int ROW_W         = 12;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 13;
  localparam int PIX_W         = 24;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_end;
  } out_beat_t;

  typedef struct packed {
    logic sum_en;
    logic mul_en;
    logic fix_en;
  } lane_ctrl_t;

  // floor(65536 / (2*count)), indexed by count (entry zero is unused)
  localparam logic [15:0] RECIP [10] = '{
    16'd0, 16'd32768, 16'd16384, 16'd10922, 16'd8192,
    16'd6553, 16'd5461, 16'd4681, 16'd4096, 16'd3640
  };

endpackage
`default_nettype wire

/* rtl/box_blur_3x3.sv */
// ============================================================================
// box_blur_3x3: streaming 3x3 RGB box blur, normalized at the frame edges
// Two line buffers feed a 3x3 window; three color lanes average it.
// ============================================================================
//
//  channel | direction | handshake             | beat
//  --------+-----------+-----------------------+-----------------------------
//  in      | input     | in_valid / in_ready   | in_beat_t (action + RGB)
//  out     | output    | out_valid / out_ready | out_beat_t (RGB + frame_end)
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index + cfg_data
//
//  A beat that produces a result passes through accept, read, shift, sum,
//  multiply, correct and load; a pixel with no result yet passes through
//  accept, read and shift; a one-row frame's last pixel adds a read and a
//  shift for the extra column. Dropped or ignored beats are only accepted.
//  The sequencer works on one beat at a time around the single-port
//  line-buffer read. Reset (rst, synchronous) clears counters, window and
//  flags; the line buffers are not cleared. A pending result waiting on
//  out_ready holds the sequencer in its load step, and input beats are held off until it leaves.
//
`default_nettype none
module box_blur_3x3
  import bb_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_beat_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_beat_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WC_W  = $clog2(MAX_WIDTH + 1);
  localparam int WU_W  = (WC_W > FW_W) ? WC_W : FW_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_FIX   = 3'd5;
  localparam logic [2:0] S_LOAD  = 3'd6;

  // Line buffers
  logic [PIX_W-1:0] row_store_upper [MAX_WIDTH];
  logic [PIX_W-1:0] row_store_lower [MAX_WIDTH];
  logic [PIX_W-1:0] upper_rd;
  logic [PIX_W-1:0] lower_rd;

  logic [FW_W-1:0]  frame_width;
  logic [FH_W-1:0]  frame_height;
  logic [8:0][PIX_W-1:0] window_regs;
  logic [COL_W-1:0] input_column;
  logic [ROW_W-1:0] input_row;
  logic [COL_W-1:0] output_column;
  logic [ROW_W-1:0] output_row;
  logic             frame_complete;

  logic [2:0]       state;
  logic             is_drain;
  logic             first_shift;
  logic             do_emit;
  logic [PIX_W-1:0] shift_pix;
  logic             frame_end;

  logic [WU_W-1:0]  wu;
  logic [FH_W-1:0]  hu;
  logic [WU_W-1:0]  in_col_ext;
  logic [WU_W-1:0]  out_col_ext;
  logic [COL_W-1:0] col_next;
  logic             in_last;
  logic             out_last_col;
  logic             out_last_row;
  logic             pix_accept;
  logic             emit_now;
  logic [8:0]       mask;
  logic [3:0]       count;
  logic [1:0]       rows_in;
  logic [1:0]       cols_in;
  logic [8:0][7:0]  px_red;
  logic [8:0][7:0]  px_green;
  logic [8:0][7:0]  px_blue;
  logic [7:0]       res_red;
  logic [7:0]       res_green;
  logic [7:0]       res_blue;
  logic             can_load;
  lane_ctrl_t       lane_ctrl;

  // Clamp the register values to the supported range
  always_comb begin
    if (frame_width == '0) begin
      wu = WU_W'(1);
    end else if (WU_W'(frame_width) > WU_W'(MAX_WIDTH)) begin
      wu = WU_W'(MAX_WIDTH);
    end else begin
      wu = WU_W'(frame_width);
    end
    if (frame_height == '0) begin
      hu = FH_W'(1);
    end else if (frame_height > FH_W'(HEIGHT_LIMIT)) begin
      hu = FH_W'(HEIGHT_LIMIT);
    end else begin
      hu = frame_height;
    end
  end

  assign in_col_ext  = WU_W'(input_column);
  assign out_col_ext = WU_W'(output_column);
  assign col_next    = (in_col_ext + WU_W'(1) >= wu) ? '0 : COL_W'(in_col_ext + WU_W'(1));
  assign in_last     = (FH_W'(input_row) >= hu - FH_W'(1)) && (in_col_ext >= wu - WU_W'(1));
  assign out_last_row = FH_W'(output_row) >= hu - FH_W'(1);
  assign out_last_col = out_col_ext >= wu - WU_W'(1);

  // Neighbor mask for the pixel being emitted: skip rows and columns off the frame
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        mask[k*3+j] = !((k == 0) && (output_row == '0)) && !((k == 2) && out_last_row)
                   && !((j == 0) && (output_column == '0)) && !((j == 2) && out_last_col);
      end
    end
    rows_in = 2'd3 - 2'(output_row == '0) - 2'(out_last_row);
    cols_in = 2'd3 - 2'(output_column == '0) - 2'(out_last_col);
    count   = 4'(rows_in) * 4'(cols_in);
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      px_red[i]   = window_regs[i][23:16];
      px_green[i] = window_regs[i][15:8];
      px_blue[i]  = window_regs[i][7:0];
    end
  end

  assign in_ready   = (state == S_IDLE);
  assign cfg_ready  = (state == S_IDLE);
  assign pix_accept = in_valid && in_ready;
  assign emit_now   = (state == S_EMIT);

  assign lane_ctrl.sum_en = (state == S_EMIT);
  assign lane_ctrl.mul_en = (state == S_MUL);
  assign lane_ctrl.fix_en = (state == S_FIX);

  // Line buffer ports: read in the read step, write in the shift step
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      upper_rd <= row_store_upper[input_column];
      lower_rd <= row_store_lower[input_column];
    end
    if (state == S_SHIFT) begin
      row_store_upper[input_column] <= lower_rd;
      row_store_lower[input_column] <= shift_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= FRAME_WIDTH_RESET;
      frame_height   <= FRAME_HEIGHT_RESET;
      window_regs    <= '0;
      input_column   <= '0;
      input_row      <= '0;
      output_column  <= '0;
      output_row     <= '0;
      frame_complete <= 1'b0;
      state          <= S_IDLE;
      is_drain       <= 1'b0;
      first_shift    <= 1'b0;
      do_emit        <= 1'b0;
      frame_end      <= 1'b0;
    end else begin
      // Register writes restart the stream position
      if (cfg_valid && cfg_ready
          && (cfg_index inside {REG_FRAME_WIDTH, REG_FRAME_HEIGHT})) begin
        if (cfg_index == REG_FRAME_WIDTH) begin
          frame_width <= cfg_data[FW_W-1:0];
        end else begin
          frame_height <= cfg_data;
        end
        window_regs    <= '0;
        input_column   <= '0;
        input_row      <= '0;
        output_column  <= '0;
        output_row     <= '0;
        frame_complete <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pix_accept) begin
            is_drain    <= (in_data.action == ACT_DRAIN);
            first_shift <= 1'b1;
            if (in_data.action == ACT_PIXEL) begin
              shift_pix <= {in_data.in_red, in_data.in_green, in_data.in_blue};
              // result is due once the input index reaches width+1
              do_emit   <= (input_row >= ROW_W'(2))
                        || ((input_row == ROW_W'(1)) && (input_column != '0));
              // drop pixels past the end of the frame
              if (!frame_complete) begin
                state <= S_READ;
              end
            end else begin
              shift_pix <= '0;
              do_emit   <= 1'b1;
              // ignore drains until the frame is complete
              if (frame_complete) begin
                state <= S_READ;
              end
            end
          end
        end
        S_READ: begin
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          for (int k = 0; k < 3; k++) begin
            window_regs[k*3]   <= window_regs[k*3+1];
            window_regs[k*3+1] <= window_regs[k*3+2];
          end
          window_regs[2] <= upper_rd;
          window_regs[5] <= lower_rd;
          window_regs[8] <= shift_pix;
          input_column   <= col_next;
          first_shift    <= 1'b0;
          if (first_shift && !is_drain) begin
            if (in_last) begin
              frame_complete <= 1'b1;
            end else if (col_next == '0) begin
              input_row <= input_row + ROW_W'(1);
            end
          end
          if (first_shift && !is_drain && in_last && (hu == FH_W'(1))) begin
            // one-row frame: push a blank column to keep the lag
            shift_pix <= '0;
            state     <= S_READ;
          end else if (do_emit) begin
            state <= S_EMIT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          frame_end <= out_last_row && out_last_col;
          if (is_drain && out_last_row && out_last_col) begin
            // last result of the frame: restart the stream position
            window_regs    <= '0;
            input_column   <= '0;
            input_row      <= '0;
            output_column  <= '0;
            output_row     <= '0;
            frame_complete <= 1'b0;
          end else if (out_col_ext + WU_W'(1) >= wu) begin
            output_column <= '0;
            if (!out_last_row) begin
              output_row <= output_row + ROW_W'(1);
            end
          end else begin
            output_column <= COL_W'(out_col_ext + WU_W'(1));
          end
          state <= S_MUL;
        end
        S_MUL: begin
          state <= S_FIX;
        end
        S_FIX: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          // hold until the output register frees up
          if (can_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  bb_lane u_lane_red (
    .clk(clk), .ctrl(lane_ctrl), .px(px_red), .mask(mask), .count(count), .result(res_red)
  );
  bb_lane u_lane_green (
    .clk(clk), .ctrl(lane_ctrl), .px(px_green), .mask(mask), .count(count),
    .result(res_green)
  );
  bb_lane u_lane_blue (
    .clk(clk), .ctrl(lane_ctrl), .px(px_blue), .mask(mask), .count(count), .result(res_blue)
  );

  bb_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .load     (state == S_LOAD),
    .red      (res_red),
    .green    (res_green),
    .blue     (res_blue),
    .last     (frame_end),
    .can_load (can_load),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Input column never reaches the used width
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    in_col_ext < wu)
    else $error("input column out of range");

  // A complete frame leaves the input row on the last row
  a_fc_row: assert property (@(posedge clk) disable iff (rst)
    frame_complete |-> (FH_W'(input_row) == hu - FH_W'(1)))
    else $error("frame complete off the last row");

  // A load step with room always presents a result next cycle
  a_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) && can_load |=> out_valid)
    else $error("result lost at load");

  // Emission only follows a shift
  a_emit: assert property (@(posedge clk) disable iff (rst)
    emit_now |-> $past(state) == S_SHIFT)
    else $error("emit without shift");

endmodule
`default_nettype wire

/* rtl/bb_lane.sv */
// ============================================================================
// bb_lane: one color channel of the blur
// Masked sum of the window, then rounded divide by the neighbor count.
// ============================================================================
`default_nettype none
module bb_lane
  import bb_pkg::*;
(
  input  wire logic             clk,
  input  wire lane_ctrl_t       ctrl,
  input  wire logic [8:0][7:0]  px,
  input  wire logic [8:0]       mask,
  input  wire logic [3:0]       count,
  output logic      [7:0]       result
);

  logic [12:0] num;
  logic [4:0]  dvs;
  logic [3:0]  cnt;
  logic [12:0] q_est;
  logic [11:0] sum;
  logic [28:0] prod;
  logic [17:0] back;
  logic [12:0] rem;

  always_comb begin
    sum = '0;
    for (int i = 0; i < 9; i++) begin
      if (mask[i]) begin
        sum = sum + 12'(px[i]);
      end
    end
  end

  assign prod = num * RECIP[cnt];
  assign back = q_est * dvs;
  assign rem  = num - back[12:0];

  always_ff @(posedge clk) begin
    if (ctrl.sum_en) begin
      num <= {sum, 1'b0} + 13'(count);
      dvs <= {count, 1'b0};
      cnt <= count;
    end
    if (ctrl.mul_en) begin
      q_est <= prod[28:16];
    end
    if (ctrl.fix_en) begin
      // estimate is exact or one short
      result <= (rem >= 13'(dvs)) ? 8'(q_est + 13'd1) : q_est[7:0];
    end
  end

endmodule
`default_nettype wire

/* rtl/bb_merge.sv */
// ============================================================================
// bb_merge: output register
// Combine the three lane results and the frame marker into one held beat.
// ============================================================================
`default_nettype none
module bb_merge
  import bb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       load,
  input  wire logic [7:0] red,
  input  wire logic [7:0] green,
  input  wire logic [7:0] blue,
  input  wire logic       last,
  output logic            can_load,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_beat_t       out_data
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load && can_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      out_data <= '{out_red: red, out_green: green, out_blue: blue, frame_end: last};
    end
  end

endmodule
`default_nettype wire

/* tb/sv/box_blur_3x3_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_blur_3x3_tb: self-checking bench for the streaming 3x3 RGB box blur
// Sends frames as valid/ready beats and models the line buffers and window to
// predict every blurred pixel. It also checks each output beat in order.
// ----------------------------------------------------------------------------
`default_nettype none
module box_blur_3x3_tb;
  import bb_pkg::*;

  localparam int MAX_W = DEF_MAX_WIDTH;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;  // no register here
  localparam int SETTLE = 24;                   // cycles for a silent beat to retire
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_BEATS = 560;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_beat_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  box_blur_3x3 u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stimulus and scoreboard storage
  in_beat_t  pending_beats[$];
  out_beat_t expected_px[$];
  int errors = 0;
  int pixels_out = 0;
  int beats_in = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_left = 0;
  int cycles = 0;

  // Mirror of the blur datapath: line buffers, window and stream position
  logic [FW_W-1:0] mdl_width = FRAME_WIDTH_RESET;
  logic [FH_W-1:0] mdl_height = FRAME_HEIGHT_RESET;
  logic [PIX_W-1:0] line_up[MAX_W];
  logic [PIX_W-1:0] line_lo[MAX_W];
  logic [PIX_W-1:0] win[9];
  int in_col, in_row, out_col, out_row;
  bit frame_done;

  function automatic int eff_width();
    if (mdl_width == 0) return 1;
    if (mdl_width > MAX_W) return MAX_W;
    return int'(mdl_width);
  endfunction

  function automatic int eff_height();
    if (mdl_height == 0) return 1;
    if (mdl_height > HEIGHT_LIMIT) return HEIGHT_LIMIT;
    return int'(mdl_height);
  endfunction

  task automatic restart_stream();
    foreach (win[k]) win[k] = '0;
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
    frame_done = 1'b0;
  endtask

  // Push one column into the window and rotate the line buffers
  task automatic push_column(logic [PIX_W-1:0] pix, int w);
    int col;
    col = (in_col >= MAX_W) ? 0 : in_col;
    for (int k = 0; k < 3; k++) begin
      win[k*3] = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = line_up[col];
    win[5] = line_lo[col];
    win[8] = pix;
    line_up[col] = line_lo[col];
    line_lo[col] = pix;
    col++;
    if (col >= w) col = 0;
    in_col = col;
  endtask

  // Average the present neighbors of the output position; queue the result
  task automatic emit_pixel(int w, int h, output bit last);
    int sum[3];
    int cnt;
    out_beat_t px;
    sum = '{0, 0, 0};
    cnt = 0;
    last = (out_row >= h - 1) && (out_col >= w - 1);
    for (int k = 0; k < 3; k++) begin
      if ((k == 0 && out_row == 0) || (k == 2 && out_row >= h - 1)) continue;
      for (int j = 0; j < 3; j++) begin
        if ((j == 0 && out_col == 0) || (j == 2 && out_col >= w - 1)) continue;
        sum[0] += win[k*3+j][23:16];
        sum[1] += win[k*3+j][15:8];
        sum[2] += win[k*3+j][7:0];
        cnt++;
      end
    end
    px.out_red = 8'((2 * sum[0] + cnt) / (2 * cnt));
    px.out_green = 8'((2 * sum[1] + cnt) / (2 * cnt));
    px.out_blue = 8'((2 * sum[2] + cnt) / (2 * cnt));
    px.frame_end = last;
    expected_px.push_back(px);
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      if (out_row < h - 1) out_row++;
    end
  endtask

  task automatic blur_predict(in_beat_t b);
    int w, h, idx;
    bit last;
    w = eff_width();
    h = eff_height();
    if (b.action == ACT_PIXEL) begin
      if (frame_done) return;  // drop pixels past the end of the frame
      idx = in_row * w + in_col;
      last = (in_row >= h - 1) && (in_col >= w - 1);
      push_column({b.in_red, b.in_green, b.in_blue}, w);
      if (last) begin
        frame_done = 1'b1;
        // a one-row frame shifts one blank column to keep the lag at w+1
        if (h == 1) push_column('0, w);
      end else if (in_col == 0) begin
        in_row++;
      end
      if (idx >= w + 1) emit_pixel(w, h, last);
    end else begin
      if (!frame_done) return;  // drain ignored mid-frame
      push_column('0, w);
      emit_pixel(w, h, last);
      if (last) restart_stream();
    end
  endtask

  initial begin
    foreach (line_up[k]) begin
      line_up[k] = '0;
      line_lo[k] = '0;
    end
    restart_stream();
  end

  task automatic report(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want,
             pixels_out);
    errors++;
  endtask

  // Driver: present the next queued beat, hold it until accepted
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        blur_predict(in_data);
        beats_in++;
      end
      if (!in_valid || in_ready) begin
        if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_valid <= 1'b1;
          in_data <= pending_beats.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each output beat against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_px.size() == 0) begin
          $display("MISMATCH unexpected output beat (result %0d)", pixels_out);
          errors++;
        end else begin
          out_beat_t want;
          want = expected_px.pop_front();
          if (out_data.out_red !== want.out_red)
            report("out_red", out_data.out_red, want.out_red);
          if (out_data.out_green !== want.out_green)
            report("out_green", out_data.out_green, want.out_green);
          if (out_data.out_blue !== want.out_blue)
            report("out_blue", out_data.out_blue, want.out_blue);
          if (out_data.frame_end !== want.frame_end)
            report("frame_end", out_data.frame_end, want.frame_end);
        end
        pixels_out++;
      end
      // long hold-off lets the block back up and stall its input
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Register writes mirror into the predictor on the handshake
  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        mdl_width = cfg_data[FW_W-1:0];
        restart_stream();
      end else if (cfg_index == REG_FRAME_HEIGHT) begin
        mdl_height = cfg_data[FH_W-1:0];
        restart_stream();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               expected_px.size());
      $display("box_blur_3x3 verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Wait for every beat to go in and every result to come out, then settle
  task automatic drain_all();
    do @(posedge clk);
    while (pending_beats.size() != 0 || in_valid || expected_px.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic add_beat(logic act, logic [23:0] rgb);
    in_beat_t b;
    b.action = act;
    {b.in_red, b.in_green, b.in_blue} = rgb;
    pending_beats.push_back(b);
  endtask

  // Queue a frame of random pixels; noisy frames add ignored and dropped beats
  task automatic queue_frame(int w, int h, int rows_sent, bit noisy);
    int n;
    n = (rows_sent < h) ? rows_sent * w + $urandom_range(w - 1) : w * h;
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(15) == 0) add_beat(ACT_DRAIN, 24'($urandom));
      add_beat(ACT_PIXEL, 24'($urandom));
    end
    if (n < w * h) return;  // abandoned frame
    if (noisy && $urandom_range(2) == 0) add_beat(ACT_PIXEL, 24'($urandom));
    for (int i = 0; i < ((h == 1) ? w : w + 1); i++) add_beat(ACT_DRAIN, 24'($urandom));
    if (noisy && $urandom_range(3) == 0) add_beat(ACT_DRAIN, 24'($urandom));
  endtask

  task automatic set_size(int w, int h);
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
  endtask

  initial begin
    int w, h, frames, rnd_start;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    drain_all();

    // Directed: 3x3 frame of black and white, a drain before the frame is
    // complete, a pixel after it, and a spare drain once the frame ends
    write_reg(REG_SPARE, '1);
    set_size(3, 3);
    for (int i = 0; i < 9; i++) begin
      add_beat(ACT_PIXEL, (i % 2) ? 24'hFFFFFF : 24'h000000);
      if (i == 4) add_beat(ACT_DRAIN, 24'hFFFFFF);
    end
    add_beat(ACT_PIXEL, 24'h808080);
    repeat (4) add_beat(ACT_DRAIN, '0);
    add_beat(ACT_DRAIN, '0);
    drain_all();

    // One-row frame, then a single pixel frame
    set_size(4, 1);
    queue_frame(4, 1, 1, 1'b0);
    drain_all();
    set_size(1, 1);
    add_beat(ACT_PIXEL, 24'hFFFFFF);
    add_beat(ACT_DRAIN, '0);
    add_beat(ACT_PIXEL, 24'h000001);
    add_beat(ACT_DRAIN, '0);
    drain_all();

    // Multi-row frame; once results flow, hold the receiver off for a long
    // stretch while pixels keep coming so the block backs up
    set_size(8, 12);
    queue_frame(8, 12, 12, 1'b0);
    wait (expected_px.size() > 0);
    hold_left = 600;
    drain_all();

    // Zero width clamps up to one, height clamps down; cut after a few rows
    set_size(0, 13'h1FFF);
    queue_frame(1, HEIGHT_LIMIT, 20, 1'b0);
    drain_all();

    // Random frames: mostly whole frames, some noisy or cut short
    rnd_start = beats_in;
    while (beats_in - rnd_start < RANDOM_BEATS) begin
      case ((beats_in - rnd_start) * 3 / RANDOM_BEATS)
        0: begin
          send_idle = 32;
          recv_idle = 65;
        end
        1: begin
          send_idle = 65;
          recv_idle = 32;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      w = ($urandom_range(7) == 0) ? $urandom_range(40, 1) : $urandom_range(8, 1);
      h = $urandom_range(6, 1);
      set_size(w, h);
      frames = $urandom_range(3, 1);
      for (int f = 0; f < frames; f++) begin
        if ($urandom_range(9) == 0) begin
          queue_frame(w, h, $urandom_range(h - 1), 1'b1);
          break;
        end
        queue_frame(w, h, h, $urandom_range(3) == 0);
      end
      drain_all();
    end

    $display("covered %0d input beats and %0d blurred pixels", beats_in, pixels_out);
    $display("frames from 1x1 to 40 wide, clamped sizes, drops and a long output stall");
    if (errors == 0) begin
      $display("box_blur_3x3 verification clean");
    end else begin
      $display("box_blur_3x3 verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
